[src/ip6ehl_pkg.sv]
// types and constants for the ipv6 extension header locator
// header type codes, result status codes, walk state record and reset values
// no dependencies
package ip6ehl_pkg;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_BAD_TYPE  = 2'd1,
        ST_NO_BEFORE = 2'd2,
        ST_TRUNC     = 2'd3
    } status_t;

    localparam logic [7:0] TYPE_TCP      = 8'd6;
    localparam logic [7:0] TYPE_IPV6     = 8'd41;
    localparam logic [7:0] TYPE_ROUTING  = 8'd43;
    localparam logic [7:0] TYPE_FRAGMENT = 8'd44;
    localparam logic [8:0] TYPE_END      = 9'd256;

    localparam logic [11:0] IPV6_HDR_LEN = 12'd40;
    localparam logic [11:0] FRAG_HDR_LEN = 12'd8;
    localparam logic [11:0] RT_HDR_BASE  = 12'd8;

    localparam logic [15:0] IPV6_NEXT_POS   = 16'd6;
    localparam logic [15:0] IPV6_ADDR_FIRST = 16'd8;
    localparam logic [15:0] IPV6_ADDR_END   = 16'd40;
    localparam logic [15:0] EXT_NEXT_POS    = 16'd0;
    localparam logic [15:0] RT_LEN_POS      = 16'd1;
    localparam logic [15:0] TCP_OFF_POS     = 16'd12;

    localparam logic [7:0] CFG_FIRST_TYPE  = 8'd0;
    localparam logic [7:0] CFG_TARGET_TYPE = 8'd1;
    localparam logic [7:0] CFG_BEFORE_TYPE = 8'd2;
    localparam logic [7:0] CFG_SUM_SEED    = 8'd3;

    localparam logic [7:0]  FIRST_TYPE_RST  = 8'd41;
    localparam logic [8:0]  TARGET_TYPE_RST = 9'd6;
    localparam logic [7:0]  BEFORE_TYPE_RST = 8'd43;
    localparam logic [15:0] SUM_SEED_RST    = 16'd0;

    localparam int MAX_PACKET_BYTES_DEF = 65535;

    typedef struct packed {
        logic [15:0] hdr_start;
        logic [11:0] hdr_len;
        logic [7:0]  cur_type;
        logic [7:0]  pend_type;
        logic        bef_valid;
        logic [15:0] bef_off;
        logic [15:0] run_sum;
        logic        decided;
    } walk_t;

    typedef struct packed {
        logic        fire;
        status_t     status;
        logic [15:0] limit;
        logic [15:0] prior;
        logic [15:0] sum;
    } result_t;

    localparam walk_t WALK_RST = '{
        hdr_start: 16'd0,
        hdr_len:   12'd0,
        cur_type:  FIRST_TYPE_RST,
        pend_type: 8'd0,
        bef_valid: 1'b0,
        bef_off:   16'd0,
        run_sum:   SUM_SEED_RST,
        decided:   1'b0
    };

endpackage

[src/ipv6_ext_header_locator_core.sv]
// ipv6 extension header locator, top level
// input beat and result beat are registered; throughput: one byte per cycle unless a held result beat stalls the walk
// the walk over one byte is one combinational pass between the input and result registers
// reset: synchronous active low, clears the walk and loads the register defaults
// depends on ip6ehl_pkg
module ipv6_ext_header_locator_core #(
    parameter int MAX_PACKET_BYTES = ip6ehl_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // addr_sum [47:32], before_offset [31:16], limit_offset [15:0]
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ip6ehl_pkg::*;

    localparam logic [16:0] MAX_POS = 17'(MAX_PACKET_BYTES);

    logic [7:0]  first_type_reg;
    logic [8:0]  target_type_reg;
    logic [7:0]  before_type_reg;
    logic [15:0] sum_seed_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    walk_t       walk_reg, walk_next;
    logic [15:0] pos_reg, pos_next;
    result_t     result_next;

    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [47:0] out_data_reg;

    logic        out_free;
    logic        advance;

    function automatic logic parseable(input logic [7:0] t);
        return (t == TYPE_IPV6) || (t == TYPE_ROUTING) || (t == TYPE_FRAGMENT) ||
               (t == TYPE_TCP);
    endfunction

    function automatic void settle(inout walk_t w, inout result_t r, input status_t st,
                                   input logic [15:0] lim, input logic [15:0] bef,
                                   input logic [15:0] sum);
        w.decided = 1'b1;
        r.fire    = 1'b1;
        r.status  = st;
        r.limit   = lim;
        r.prior   = bef;
        r.sum     = sum;
    endfunction

    function automatic void finish_found(inout walk_t w, inout result_t r,
                                         input logic [15:0] lim);
        if (w.bef_valid && (w.bef_off < lim)) begin
            settle(w, r, ST_FOUND, lim, w.bef_off, w.run_sum);
        end else begin
            settle(w, r, ST_NO_BEFORE, lim, 16'd0, w.run_sum);
        end
    endfunction

    function automatic void enter_hdr(inout walk_t w, inout result_t r,
                                      input logic [8:0] tgt, input logic [7:0] bef);
        if (!parseable(w.cur_type)) begin
            settle(w, r, ST_BAD_TYPE, 16'd0, 16'd0, 16'd0);
        end else if ({1'b0, w.cur_type} == tgt) begin
            finish_found(w, r, w.hdr_start);
        end else begin
            if (w.cur_type == bef) begin
                w.bef_valid = 1'b1;
                w.bef_off   = w.hdr_start;
            end
            if ((w.cur_type == TYPE_TCP) && (tgt != TYPE_END)) begin
                settle(w, r, ST_BAD_TYPE, 16'd0, 16'd0, 16'd0);
            end else begin
                if (w.cur_type == TYPE_IPV6) begin
                    w.hdr_len = IPV6_HDR_LEN;
                end else if (w.cur_type == TYPE_TCP) begin
                    w.hdr_len = 12'd0;
                end else begin
                    w.hdr_len = FRAG_HDR_LEN;
                end
                w.pend_type = 8'd0;
            end
        end
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_type_reg  <= FIRST_TYPE_RST;
            target_type_reg <= TARGET_TYPE_RST;
            before_type_reg <= BEFORE_TYPE_RST;
            sum_seed_reg    <= SUM_SEED_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FIRST_TYPE:  first_type_reg  <= cfg_data[7:0];
                CFG_TARGET_TYPE: target_type_reg <= cfg_data[8:0];
                CFG_BEFORE_TYPE: before_type_reg <= cfg_data[7:0];
                CFG_SUM_SEED:    sum_seed_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb begin : walk_step
        walk_t       w;
        result_t     r;
        logic [15:0] pos;
        logic [15:0] rel;
        logic [7:0]  t;
        logic [16:0] s17;
        logic [16:0] lim;

        w   = walk_reg;
        pos = pos_reg;
        r   = '{fire: 1'b0, status: ST_FOUND, limit: 16'd0, prior: 16'd0, sum: 16'd0};
        rel = 16'd0;
        t   = 8'd0;
        s17 = 17'd0;
        lim = 17'd0;

        if (!w.decided && (pos == 16'd0)) begin
            w.cur_type  = first_type_reg;
            w.run_sum   = sum_seed_reg;
            w.hdr_start = 16'd0;
            enter_hdr(w, r, target_type_reg, before_type_reg);
        end

        if (!w.decided) begin
            if ({1'b0, pos} >= MAX_POS) begin
                settle(w, r, ST_TRUNC, 16'd0, 16'd0, 16'd0);
            end else begin
                t   = w.cur_type;
                rel = pos - w.hdr_start;
                case (t)
                    TYPE_IPV6: begin
                        if (rel == IPV6_NEXT_POS) w.pend_type = in_byte_reg;
                        if ((rel >= IPV6_ADDR_FIRST) && (rel < IPV6_ADDR_END)) begin
                            s17 = {1'b0, w.run_sum} +
                                  (rel[0] ? {9'd0, in_byte_reg} : {1'b0, in_byte_reg, 8'd0});
                            w.run_sum = s17[15:0] + {15'd0, s17[16]};
                        end
                    end
                    TYPE_ROUTING: begin
                        if (rel == EXT_NEXT_POS) w.pend_type = in_byte_reg;
                        if (rel == RT_LEN_POS) w.hdr_len = RT_HDR_BASE + {1'b0, in_byte_reg, 3'b000};
                    end
                    TYPE_FRAGMENT: begin
                        if (rel == EXT_NEXT_POS) w.pend_type = in_byte_reg;
                    end
                    TYPE_TCP: begin
                        if (rel == TCP_OFF_POS) begin
                            lim = {1'b0, w.hdr_start} + {11'd0, in_byte_reg[7:4], 2'b00};
                            if (lim > MAX_POS) begin
                                settle(w, r, ST_TRUNC, 16'd0, 16'd0, 16'd0);
                            end else begin
                                finish_found(w, r, lim[15:0]);
                            end
                        end
                    end
                    default: ;
                endcase
                pos = pos + 16'd1;
                if (!w.decided && (t != TYPE_TCP) &&
                    (({1'b0, rel} + 17'd1) == {5'd0, w.hdr_len})) begin
                    w.hdr_start = pos;
                    w.cur_type  = w.pend_type;
                    enter_hdr(w, r, target_type_reg, before_type_reg);
                end
            end
        end

        if (in_last_reg && !w.decided) begin
            settle(w, r, ST_TRUNC, 16'd0, 16'd0, 16'd0);
        end

        // end of packet restarts the walk
        if (in_last_reg) begin
            w   = WALK_RST;
            pos = 16'd0;
        end

        walk_next   = w;
        pos_next    = pos;
        result_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg <= WALK_RST;
            pos_reg  <= 16'd0;
        end else if (advance) begin
            walk_reg <= walk_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && result_next.fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result_next.fire) begin
            out_status_reg <= result_next.status;
            out_data_reg   <= {result_next.sum, result_next.prior, result_next.limit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for ipv6_ext_header_locator_core: feeds packet bytes, predicts each
// locate result with a behavioral header walk and checks every result beat field by field
// depends on ip6ehl_pkg and the core's rtl
module testbench;
    import ip6ehl_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        status_t     status;
        bit [15:0]   lim_off;
        bit [15:0]   prior_off;
        bit [15:0]   addr_sum;
    } locate_t;

    class header_walk;
        bit [7:0]  first_type;
        bit [8:0]  target_type;
        bit [7:0]  before_type;
        bit [15:0] sum_seed;

        bit [15:0] pos;
        bit [15:0] hstart;
        bit [11:0] hlen;
        bit [7:0]  cur;
        bit [7:0]  pend;
        bit        prior_valid;
        bit [15:0] prior_off;
        bit [15:0] rsum;
        bit        decided;

        locate_t   pending_locs[$];
        int        locs_predicted;
        int        errors;

        function new();
            first_type  = FIRST_TYPE_RST;
            target_type = TARGET_TYPE_RST;
            before_type = BEFORE_TYPE_RST;
            sum_seed    = SUM_SEED_RST;
            restart();
        endfunction

        function void set_reg(bit [7:0] idx, bit [15:0] val);
            case (idx)
                CFG_FIRST_TYPE:  first_type  = val[7:0];
                CFG_TARGET_TYPE: target_type = val[8:0];
                CFG_BEFORE_TYPE: before_type = val[7:0];
                CFG_SUM_SEED:    sum_seed    = val;
                default: ;
            endcase
        endfunction

        function void restart();
            pos         = 0;
            hstart      = 0;
            hlen        = 0;
            cur         = first_type;
            pend        = 0;
            prior_valid = 0;
            prior_off   = 0;
            rsum        = sum_seed;
            decided     = 0;
        endfunction

        function void settle(status_t st, bit [15:0] lim, bit [15:0] bef, bit [15:0] sum);
            locate_t r;
            r.status    = st;
            r.lim_off   = lim;
            r.prior_off = bef;
            r.addr_sum  = sum;
            decided = 1;
            pending_locs.push_back(r);
            locs_predicted++;
        endfunction

        function void finish_found(int lim);
            if (prior_valid && int'(prior_off) < lim) settle(ST_FOUND, 16'(lim), prior_off, rsum);
            else settle(ST_NO_BEFORE, 16'(lim), 0, rsum);
        endfunction

        function void enter_header();
            if (!(cur == TYPE_IPV6 || cur == TYPE_ROUTING || cur == TYPE_FRAGMENT ||
                  cur == TYPE_TCP)) begin
                settle(ST_BAD_TYPE, 0, 0, 0);
                return;
            end
            if ({1'b0, cur} == target_type) begin
                finish_found(hstart);
                return;
            end
            if (cur == before_type) begin
                prior_valid = 1;
                prior_off   = hstart;
            end
            if (cur == TYPE_TCP && target_type != TYPE_END) begin
                settle(ST_BAD_TYPE, 0, 0, 0);
                return;
            end
            if (cur == TYPE_IPV6) hlen = IPV6_HDR_LEN;
            else if (cur == TYPE_TCP) hlen = 0;
            else if (cur == TYPE_ROUTING) hlen = RT_HDR_BASE;
            else hlen = FRAG_HDR_LEN;
            pend = 0;
        endfunction

        function void absorb(bit [7:0] b);
            bit [15:0] rel;
            bit [16:0] s;
            bit [7:0]  t;
            int        lim;
            t   = cur;
            rel = pos - hstart;
            case (t)
                TYPE_IPV6: begin
                    if (rel == IPV6_NEXT_POS) pend = b;
                    if (rel >= IPV6_ADDR_FIRST && rel < IPV6_ADDR_END) begin
                        s    = rsum + (rel[0] ? {8'd0, b} : {b, 8'd0});
                        rsum = s[15:0] + s[16];
                    end
                end
                TYPE_ROUTING: begin
                    if (rel == EXT_NEXT_POS) pend = b;
                    if (rel == RT_LEN_POS) hlen = RT_HDR_BASE + {1'b0, b, 3'b000};
                end
                TYPE_FRAGMENT: begin
                    if (rel == EXT_NEXT_POS) pend = b;
                end
                TYPE_TCP: begin
                    if (rel == TCP_OFF_POS) begin
                        lim = int'(hstart) + 4 * int'(b[7:4]);
                        if (lim > MAX_PACKET_BYTES_DEF) settle(ST_TRUNC, 0, 0, 0);
                        else finish_found(lim);
                    end
                end
                default: ;
            endcase
            pos++;
            if (!decided && t != TYPE_TCP && int'(rel) + 1 == int'(hlen)) begin
                hstart = pos;
                cur    = pend;
                enter_header();
            end
        endfunction

        function void take_byte(bit [7:0] b, bit last);
            if (!decided && pos == 0) begin
                cur    = first_type;
                rsum   = sum_seed;
                hstart = 0;
                enter_header();
            end
            if (!decided) begin
                if (int'(pos) >= MAX_PACKET_BYTES_DEF) settle(ST_TRUNC, 0, 0, 0);
                else absorb(b);
            end
            if (last && !decided) settle(ST_TRUNC, 0, 0, 0);
            if (last) restart();
        endfunction

        function void match_result(status_t st, bit [15:0] lim, bit [15:0] bef,
                                   bit [15:0] sum);
            locate_t e;
            if (pending_locs.size() == 0) begin
                $error("result beat with nothing expected: status %0d", st);
                errors++;
                return;
            end
            e = pending_locs.pop_front();
            if (e.status != st) begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (e.lim_off != lim) begin
                $error("limit_offset: expected %0d, actual %0d", e.lim_off, lim);
                errors++;
            end
            if (e.prior_off != bef) begin
                $error("before_offset: expected %0d, actual %0d", e.prior_off, bef);
                errors++;
            end
            if (e.addr_sum != sum) begin
                $error("addr_sum: expected %04h, actual %04h", e.addr_sum, sum);
                errors++;
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'd0;
    logic [15:0] cfg_data  = 16'd0;

    header_walk  walk;
    bit [7:0]    pkt[$];
    int          bytes_sent;
    int          cycle_count;
    int          snk_hold;
    bit          src_idle_on;
    bit          snk_idle_on;

    ipv6_ext_header_locator_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: check each beat, stall in random bursts
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                walk.match_result(status_t'(m_tuser), m_tdata[15:0], m_tdata[31:16],
                                  m_tdata[47:32]);
            if (snk_hold > 0) begin
                snk_hold--;
                m_tready <= 1'b0;
            end else if (snk_idle_on && $urandom_range(0, 4) == 0) begin
                snk_hold = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void add_ipv6(bit [7:0] nxt, bit max_addr);
        for (int i = 0; i < 40; i++) begin
            if (i == IPV6_NEXT_POS) pkt.push_back(nxt);
            else if (max_addr && i >= IPV6_ADDR_FIRST) pkt.push_back(8'hff);
            else pkt.push_back(8'($urandom));
        end
    endfunction

    function automatic void add_routing(bit [7:0] nxt, bit [7:0] segs);
        int n;
        n = int'(RT_HDR_BASE) + 8 * int'(segs);
        for (int i = 0; i < n; i++) begin
            if (i == EXT_NEXT_POS) pkt.push_back(nxt);
            else if (i == RT_LEN_POS) pkt.push_back(segs);
            else pkt.push_back(8'($urandom));
        end
    endfunction

    function automatic void add_frag(bit [7:0] nxt);
        for (int i = 0; i < FRAG_HDR_LEN; i++)
            pkt.push_back(i == EXT_NEXT_POS ? nxt : 8'($urandom));
    endfunction

    function automatic void add_tcp(bit [3:0] doff);
        for (int i = 0; i < 20; i++)
            pkt.push_back(i == TCP_OFF_POS ? {doff, 4'($urandom)} : 8'($urandom));
    endfunction

    function automatic void add_noise(int n);
        repeat (n) pkt.push_back(8'($urandom));
    endfunction

    function automatic void cut_to(int n);
        while (pkt.size() > n) void'(pkt.pop_back());
    endfunction

    function automatic bit [7:0] pick_type();
        case ($urandom_range(0, 8))
            0, 1:    return TYPE_TCP;
            2, 3:    return TYPE_IPV6;
            4, 5:    return TYPE_ROUTING;
            6, 7:    return TYPE_FRAGMENT;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly well-formed chains from the configured first type, some cut short or corrupted, some pure noise
    function automatic void make_packet();
        bit [7:0] t;
        bit [7:0] nt;
        bit       stop;
        if ($urandom_range(0, 9) == 0) begin
            add_noise($urandom_range(1, 24));
            return;
        end
        t    = walk.first_type;
        stop = 0;
        for (int n = 0; n < 5 && !stop; n++) begin
            nt = pick_type();
            case (t)
                TYPE_IPV6:     add_ipv6(nt, $urandom_range(0, 5) == 0);
                TYPE_ROUTING:  add_routing(nt, ($urandom_range(0, 15) == 0) ?
                                   $urandom_range(0, 40) : $urandom_range(0, 2));
                TYPE_FRAGMENT: add_frag(nt);
                TYPE_TCP: begin
                    add_tcp($urandom_range(0, 15));
                    stop = 1;
                end
                default: begin
                    add_noise($urandom_range(1, 8));
                    stop = 1;
                end
            endcase
            t = nt;
        end
        add_noise($urandom_range(0, 4));
        case ($urandom_range(0, 7))
            0, 1: cut_to($urandom_range(1, pkt.size()));
            2:    pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
            default: ;
        endcase
    endfunction

    task automatic send_byte(bit [7:0] d, bit last);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        walk.take_byte(d, last);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        bytes_sent += pkt.size();
        pkt.delete();
    endtask

    // block idle: every expected result in, then room for a byte still in flight
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (walk.pending_locs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(bit [7:0] idx, bit [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        walk.set_reg(idx, val);
    endtask

    task automatic apply_config(bit [7:0] ft, bit [8:0] tt, bit [7:0] bt, bit [15:0] seed);
        wait_idle();
        write_reg(CFG_FIRST_TYPE, {8'd0, ft});
        write_reg(CFG_TARGET_TYPE, {7'd0, tt});
        write_reg(CFG_BEFORE_TYPE, {8'd0, bt});
        write_reg(CFG_SUM_SEED, seed);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int rand_start;
        int locs_start;
        walk        = new();
        src_idle_on = 1;
        snk_idle_on = 1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults: ipv6 first, locate tcp, report last routing header
        add_ipv6(TYPE_ROUTING, 0); add_routing(TYPE_FRAGMENT, 0); add_frag(TYPE_TCP);
        add_tcp(5); send_packet();
        add_ipv6(TYPE_ROUTING, 1); add_routing(TYPE_ROUTING, 1); add_routing(TYPE_TCP, 0);
        add_tcp(5); send_packet();
        add_ipv6(TYPE_TCP, 0); add_tcp(5); send_packet();
        add_ipv6(8'd17, 0); add_noise(8); send_packet();
        add_ipv6(TYPE_ROUTING, 0); cut_to(20); send_packet();
        add_noise(1); send_packet();
        add_ipv6(TYPE_IPV6, 0); add_ipv6(TYPE_ROUTING, 1); add_routing(TYPE_TCP, 6);
        add_tcp(5); send_packet();
        add_ipv6(TYPE_FRAGMENT, 0); add_frag(TYPE_ROUTING); add_routing(8'd59, 0);
        add_noise(4); send_packet();

        // end of chain after tcp, tcp as the earlier header
        apply_config(TYPE_IPV6, TYPE_END, TYPE_TCP, 16'hffff);
        add_ipv6(TYPE_TCP, 1); add_tcp(0); send_packet();
        add_ipv6(TYPE_TCP, 1); add_tcp(15); send_packet();
        add_ipv6(TYPE_ROUTING, 0); add_routing(TYPE_TCP, 0); add_tcp(5); cut_to(58);
        send_packet();

        apply_config(8'd0, 9'd0, 8'd0, 16'd0);
        add_noise(3); send_packet();
        apply_config(8'd255, 9'd0, 8'd255, 16'h8000);
        add_noise(3); send_packet();
        apply_config(TYPE_ROUTING, {1'b0, TYPE_ROUTING}, 8'd255, 16'h1234);
        add_routing(TYPE_TCP, 0); add_tcp(5); send_packet();
        apply_config(TYPE_FRAGMENT, {1'b0, TYPE_IPV6}, TYPE_FRAGMENT, 16'd0);
        add_frag(TYPE_IPV6); add_ipv6(TYPE_TCP, 0); add_tcp(5); send_packet();
        apply_config(TYPE_IPV6, {1'b0, TYPE_FRAGMENT}, TYPE_IPV6, 16'hfffe);
        add_ipv6(TYPE_TCP, 0); add_tcp(5); send_packet();
        add_ipv6(TYPE_FRAGMENT, 1); add_frag(TYPE_TCP); send_packet();
        apply_config(TYPE_IPV6, 9'd17, TYPE_ROUTING, 16'd0);
        add_ipv6(TYPE_ROUTING, 0); add_routing(8'd17, 0); add_noise(6); send_packet();

        rand_start = bytes_sent;
        locs_start = walk.locs_predicted;
        while (bytes_sent - rand_start < 150 || walk.locs_predicted - locs_start < 4) begin
            apply_config(($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_type(),
                         ($urandom_range(0, 3) == 0) ? TYPE_END : {1'b0, pick_type()},
                         pick_type(), 16'($urandom));
            repeat ($urandom_range(4, 10)) begin
                src_idle_on = $urandom_range(0, 3) != 0;
                snk_idle_on = $urandom_range(0, 3) != 0;
                make_packet();
                send_packet();
            end
        end

        // closing stretch with no idling
        apply_config(TYPE_IPV6, TYPE_END, TYPE_ROUTING, 16'($urandom));
        src_idle_on = 0;
        snk_idle_on = 0;
        repeat (3) begin
            make_packet();
            send_packet();
        end
        wait_idle();

        if (walk.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
